// ----- hdl/dlwc_pkg.sv -----
// ----------------------------------------------------------------------------
// dlwc_pkg
// Shared types and constants of the delay and loss window controller.
// ----------------------------------------------------------------------------
package dlwc_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEND_CHK,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_SETTLE_RD,
    ST_SETTLE_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RTT_MUL,
    ST_RTT_SUM,
    ST_WINDOW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] short_term;
    logic [15:0] long_term;
  } loss_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [31:0] stamp;
  } entry_t;

  localparam logic [1:0] CFG_REORDER_WINDOW = 2'd0;
  localparam logic [1:0] CFG_MIN_WINDOW     = 2'd1;

  localparam logic [16:0] SHORT_KEEP = 17'd62259;
  localparam logic [31:0] SHORT_GAIN = 32'd214761472;
  localparam logic [16:0] LONG_KEEP  = 17'd65470;
  localparam logic [31:0] LONG_GAIN  = 32'd4325376;
  localparam logic [11:0] RTT_GAIN   = 12'd3277;
  localparam logic [15:0] RTT_KEEP   = 16'd62259;

  localparam logic [15:0] LOSS_05 = 16'd3277;
  localparam logic [15:0] LOSS_10 = 16'd6554;
  localparam logic [15:0] LOSS_25 = 16'd16384;
  localparam logic [15:0] LOSS_30 = 16'd19661;
  localparam logic [15:0] LOSS_50 = 16'd32768;

  localparam logic [31:0] RTT_MARGIN_FAST = 32'd20;
  localparam logic [31:0] RTT_MARGIN_SLOW = 32'd100;
  localparam logic [31:0] RTT_MARGIN_LONG = 32'd500;
  localparam logic [31:0] RTT_MARGIN_HIGH = 32'd1000;
  localparam logic [31:0] HOLD_SHORT      = 32'd20;
  localparam logic [31:0] HOLD_LONG       = 32'd200;

  localparam logic [39:0] RTT_RESET     = 40'd25600;
  localparam logic [31:0] RTT_MIN_RESET = 32'd1000;

  function automatic logic [15:0] loss_step(input logic [15:0] l, input logic [16:0] keep,
                                            input logic [31:0] gain, input logic lost);
    logic [32:0] acc;
    acc = 33'(l) * 33'(keep) + 33'd32768 + (lost ? 33'(gain) : 33'd0);
    return acc[31:16];
  endfunction

endpackage

// ----- hdl/delay_loss_window_controller.sv -----
// ----------------------------------------------------------------------------
// delay_loss_window_controller
// Sender congestion window controller with a ring of outstanding packets.
//
//   channel  handshake          payload
//   input    in_valid/in_stall  command, packet_seq, send_time, ack_time
//   output   out_valid/out_stall window_size, in_flight, window_open,
//                               send_rejected, rtt_average
//   config   cfg_write          cfg_index, cfg_data
//
// A send checks the tail slot and writes the packet there if it is free. An
// ack drops expired entries at the head, scans the ring for the acked
// sequence (the scan ends on a hit or a larger sequence), moves the head past
// empty slots after a removal at the head and updates the RTT and window.
// After reset a clearing pass writes every ring slot before any request.
// A finished result waits in the output register; the next request may start
// meanwhile and holds at its end until the output is free.
// ----------------------------------------------------------------------------
module delay_loss_window_controller #(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] packet_seq,
  input  logic [31:0] send_time,
  input  logic [31:0] ack_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  window_size,
  output logic [8:0]  in_flight,
  output logic        window_open,
  output logic        send_rejected,
  output logic [39:0] rtt_average,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dlwc_pkg::*;

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CNTW = $clog2(RING_DEPTH+1);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(RING_DEPTH-1)) ? '0 : i + 1'b1;
  endfunction

  entry_t mem [RING_DEPTH];
  entry_t rd_data, mem_wdata;
  logic   mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  state_t state, state_next;
  logic [AW-1:0]   head, head_next, tail, tail_next, idx, idx_next, clear_addr, clear_addr_next;
  logic [CNTW-1:0] count, count_next, seen, seen_next, cw, cw_next, cw_rule;
  logic [31:0]     wct, wct_next, rtt_min, rtt_min_next, rtt;
  logic [39:0]     rtt_s, rtt_s_next;
  logic [43:0]     prod, prod_next;
  logic [56:0]     rtt_sum;
  loss_t           loss, loss_next;
  logic            settle_to_rtt, settle_to_rtt_next, rejected, rejected_next, rule_changed;
  logic            load_out;
  logic [15:0]     reorder_window;
  logic [8:0]      min_window;
  logic [31:0]     seq_r, sent_r, ack_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reorder_window <= 16'd20;
      min_window     <= 9'd2;
    end else if (cfg_write) begin
      if (cfg_index == CFG_REORDER_WINDOW) reorder_window <= cfg_data;
      if (cfg_index == CFG_MIN_WINDOW) min_window <= cfg_data[8:0];
    end
  end

  dlwc_rules #(.RING_DEPTH(RING_DEPTH)) u_rules (
    .cw          (cw),
    .change_time (wct),
    .ack_time    (ack_r),
    .loss        (loss),
    .rtt_s       (rtt_s),
    .rtt_min     (rtt_min),
    .min_window  (min_window),
    .cw_next     (cw_rule),
    .changed     (rule_changed)
  );

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      head          <= '0;
      tail          <= '0;
      idx           <= '0;
      clear_addr    <= '0;
      count         <= '0;
      seen          <= '0;
      cw            <= CNTW'(2);
      wct           <= '0;
      rtt_min       <= RTT_MIN_RESET;
      rtt_s         <= RTT_RESET;
      loss          <= '0;
      settle_to_rtt <= 1'b0;
      rejected      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      idx           <= idx_next;
      clear_addr    <= clear_addr_next;
      count         <= count_next;
      seen          <= seen_next;
      cw            <= cw_next;
      wct           <= wct_next;
      rtt_min       <= rtt_min_next;
      rtt_s         <= rtt_s_next;
      loss          <= loss_next;
      settle_to_rtt <= settle_to_rtt_next;
      rejected      <= rejected_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (in_valid && state == ST_IDLE) begin
      seq_r  <= packet_seq;
      sent_r <= send_time;
      ack_r  <= ack_time;
    end
    if (load_out) begin
      window_size   <= 9'(cw);
      in_flight     <= 9'(count);
      window_open   <= count < cw;
      send_rejected <= rejected;
      rtt_average   <= rtt_s;
    end
  end

  always_comb begin
    rtt     = ack_r - sent_r;
    rtt_sum = 57'({prod, 8'b0}) + 57'(rtt_s) * 57'(RTT_KEEP) + 57'd32768;
  end

  always_comb begin
    state_next         = state;
    head_next          = head;
    tail_next          = tail;
    idx_next           = idx;
    clear_addr_next    = clear_addr;
    count_next         = count;
    seen_next          = seen;
    cw_next            = cw;
    wct_next           = wct;
    rtt_min_next       = rtt_min;
    rtt_s_next         = rtt_s;
    loss_next          = loss;
    settle_to_rtt_next = settle_to_rtt;
    rejected_next      = rejected;
    prod_next          = prod;
    load_out           = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = head;
    mem_wdata          = '0;
    mem_raddr          = head;
    unique case (state)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clear_addr;
        clear_addr_next = next_slot(clear_addr);
        if (clear_addr == AW'(RING_DEPTH-1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        mem_raddr     = tail;
        rejected_next = 1'b0;
        if (in_valid) state_next = command ? ST_EXP_RD : ST_SEND_CHK;
      end
      ST_SEND_CHK: begin
        if (rd_data.valid) begin
          rejected_next = 1'b1;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = tail;
          mem_wdata  = '{valid: 1'b1, seq: seq_r, stamp: sent_r};
          if (count == '0) head_next = tail;
          tail_next  = next_slot(tail);
          count_next = count + 1'b1;
        end
        state_next = ST_FINISH;
      end
      ST_EXP_RD: begin
        if (count == '0) begin
          idx_next   = head;
          seen_next  = '0;
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if ((33'(rd_data.stamp) + 33'(reorder_window)) < 33'(sent_r)) begin
          mem_we     = 1'b1;
          mem_waddr  = head;
          count_next = count - 1'b1;
          loss_next.short_term = loss_step(loss.short_term, SHORT_KEEP, SHORT_GAIN, 1'b1);
          loss_next.long_term  = loss_step(loss.long_term, LONG_KEEP, LONG_GAIN, 1'b1);
          if (count == CNTW'(1)) begin
            head_next  = tail;
            state_next = ST_EXP_RD;
          end else begin
            head_next          = next_slot(head);
            settle_to_rtt_next = 1'b0;
            state_next         = ST_SETTLE_RD;
          end
        end else begin
          idx_next   = head;
          seen_next  = '0;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SETTLE_RD: begin
        state_next = ST_SETTLE_CHK;
      end
      ST_SETTLE_CHK: begin
        if (rd_data.valid) begin
          state_next = settle_to_rtt ? ST_RTT_MUL : ST_EXP_CHK;
        end else begin
          head_next  = next_slot(head);
          state_next = ST_SETTLE_RD;
        end
      end
      ST_SCAN_RD: begin
        mem_raddr  = idx;
        state_next = (seen == count) ? ST_RTT_MUL : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_next = ST_SCAN_RD;
        idx_next   = next_slot(idx);
        if (rd_data.valid) begin
          seen_next = seen + 1'b1;
          if (rd_data.seq == seq_r) begin
            mem_we     = 1'b1;
            mem_waddr  = idx;
            count_next = count - 1'b1;
            loss_next.short_term = loss_step(loss.short_term, SHORT_KEEP, SHORT_GAIN, 1'b0);
            loss_next.long_term  = loss_step(loss.long_term, LONG_KEEP, LONG_GAIN, 1'b0);
            state_next = ST_RTT_MUL;
            if (count == CNTW'(1)) begin
              head_next = tail;
            end else if (idx == head) begin
              head_next          = next_slot(head);
              settle_to_rtt_next = 1'b1;
              state_next         = ST_SETTLE_RD;
            end
          end else if (rd_data.seq > seq_r) begin
            state_next = ST_RTT_MUL;
          end
        end
      end
      ST_RTT_MUL: begin
        if (rtt < rtt_min) rtt_min_next = rtt;
        prod_next  = 44'(rtt) * 44'(RTT_GAIN);
        state_next = ST_RTT_SUM;
      end
      ST_RTT_SUM: begin
        rtt_s_next = rtt_sum[55:16];
        state_next = ST_WINDOW;
      end
      ST_WINDOW: begin
        cw_next = cw_rule;
        if (rule_changed) wct_next = ack_r;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!(out_valid && out_stall)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(RING_DEPTH)) else $error("pending count exceeds ring depth");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (cw >= CNTW'(1)) && (cw <= CNTW'(RING_DEPTH))) else $error("window out of range");

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && count == '0) |-> (head == tail))
    else $error("empty ring with head off tail");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH)) else $error("result without finish");

endmodule

// ----- hdl/dlwc_rules.sv -----
// ----------------------------------------------------------------------------
// dlwc_rules
// Short-term and long-term window rules with floor and ceiling clamp.
// ----------------------------------------------------------------------------
module dlwc_rules #(
  parameter int RING_DEPTH = 256
) (
  input  logic [$clog2(RING_DEPTH+1)-1:0] cw,
  input  logic [31:0]                     change_time,
  input  logic [31:0]                     ack_time,
  input  dlwc_pkg::loss_t                 loss,
  input  logic [39:0]                     rtt_s,
  input  logic [31:0]                     rtt_min,
  input  logic [8:0]                      min_window,
  output logic [$clog2(RING_DEPTH+1)-1:0] cw_next,
  output logic                            changed
);
  import dlwc_pkg::*;

  localparam int CNTW = $clog2(RING_DEPTH+1);
  localparam int WW   = ((CNTW > 9) ? CNTW : 9) + 2;

  logic [40:0]          thr_fast, thr_slow, thr_long, thr_high, s_ext;
  logic                 short_due, long_due, fired_a, dec_loss, s_ok, inc_b, dec_b;
  logic signed [3:0]    delta;
  logic [8:0]           floor_w;
  logic signed [WW-1:0] w;

  always_comb begin
    s_ext    = {1'b0, rtt_s};
    thr_fast = {33'(rtt_min) + 33'(RTT_MARGIN_FAST), 8'b0};
    thr_slow = {33'(rtt_min) + 33'(RTT_MARGIN_SLOW), 8'b0};
    thr_long = {33'(rtt_min) + 33'(RTT_MARGIN_LONG), 8'b0};
    thr_high = {33'(rtt_min) + 33'(RTT_MARGIN_HIGH), 8'b0};
    short_due = (33'(change_time) + 33'(HOLD_SHORT)) < 33'(ack_time);
    long_due  = (33'(change_time) + 33'(HOLD_LONG)) < 33'(ack_time);
    delta   = 4'sd0;
    fired_a = 1'b0;
    if (short_due && loss.short_term < LOSS_10 && loss.long_term < LOSS_05) begin
      if (s_ext < thr_fast) begin
        delta   = 4'sd2;
        fired_a = 1'b1;
      end else if (s_ext < thr_slow) begin
        delta   = 4'sd1;
        fired_a = 1'b1;
      end
    end
    dec_loss = 1'b0;
    inc_b    = 1'b0;
    dec_b    = 1'b0;
    s_ok     = loss.short_term < LOSS_50 && loss.long_term < LOSS_10;
    if (!fired_a && long_due) begin
      dec_loss = loss.short_term > LOSS_30 && loss.long_term > LOSS_25;
      inc_b    = s_ok && (s_ext < thr_long);
      dec_b    = !s_ok && (s_ext > thr_high);
      delta    = (inc_b ? 4'sd1 : 4'sd0) - (dec_loss ? 4'sd1 : 4'sd0) - (dec_b ? 4'sd1 : 4'sd0);
    end
    changed = fired_a || dec_loss || inc_b || dec_b;
    floor_w = (min_window == 9'd0) ? 9'd1 : min_window;
    w = $signed(WW'(cw)) + WW'(delta);
    if (w < $signed(WW'(floor_w))) w = $signed(WW'(floor_w));
    if (w > $signed(WW'(RING_DEPTH))) w = $signed(WW'(RING_DEPTH));
    cw_next = CNTW'(w);
  end

endmodule
